FILE: rtl/lkc_pkg.sv
package lkc_pkg;

    localparam int CAP_W       = 5;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0]        CAP_RESET  = CAP_W'(16);
    localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [KEY_W-1:0]    key;
        logic signed [VAL_W-1:0]    value;
    } t_req;

    typedef struct packed {
        logic                       found;
        logic signed [VAL_W-1:0]    value;
    } t_rsp;

endpackage

FILE: rtl/lkc_if.sv
interface lkc_req_if;
    import lkc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic signed [KEY_W-1:0]    lookup_key;
    logic signed [VAL_W-1:0]    write_value;

    modport source (output valid, output operation, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input operation, input lookup_key, input write_value,
                    output ready);
endinterface

interface lkc_rsp_if;
    import lkc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       found;
    logic signed [VAL_W-1:0]    read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

interface lkc_cfg_if;
    import lkc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CAP_W-1:0]           active_capacity;

    modport source (output valid, output active_capacity, input ready);
    modport sink   (input valid, input active_capacity, output ready);
endinterface

FILE: rtl/lkc_core.sv
module lkc_core #(
    parameter int ENTRIES = lkc_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  lkc_pkg::t_req               i_req,
    input  logic [lkc_pkg::CAP_W-1:0]   i_capacity,
    output lkc_pkg::t_rsp               o_rsp
);
    import lkc_pkg::*;

    localparam int RW = $clog2(ENTRIES);
    localparam int OW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]         r_valid;
    logic signed [KEY_W-1:0]    r_key   [ENTRIES];
    logic signed [VAL_W-1:0]    r_val   [ENTRIES];
    logic [RW-1:0]              r_rank  [ENTRIES];
    logic [OW-1:0]              r_occ;

    logic [ENTRIES-1:0]         n_valid;
    logic signed [KEY_W-1:0]    n_key   [ENTRIES];
    logic signed [VAL_W-1:0]    n_val   [ENTRIES];
    logic [RW-1:0]              n_rank  [ENTRIES];
    logic [OW-1:0]              n_occ;

    logic [ENTRIES-1:0]         hit;
    logic                       hit_any;
    logic [RW-1:0]              hit_rank;
    logic signed [VAL_W-1:0]    hit_value;
    logic [ENTRIES-1:0]         free_slot;
    logic [ENTRIES-1:0]         victim;
    logic [ENTRIES-1:0]         slot;
    logic                       evict;
    logic                       is_put;
    logic [RW-1:0]              last_rank;

    assign is_put    = (i_req.op == OP_PUT);
    assign free_slot = ~r_valid & (r_valid + ENTRIES'(1));
    assign last_rank = RW'(r_occ - OW'(1));

    always_comb begin
        if (i_capacity == '0) begin
            evict = (r_occ != '0);
        end else if (32'(i_capacity) >= ENTRIES) begin
            evict = (32'(r_occ) >= ENTRIES);
        end else begin
            evict = (32'(r_occ) >= 32'(i_capacity));
        end
    end

    always_comb begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit[i]    = r_valid[i] && (r_key[i] == i_req.key);
            victim[i] = r_valid[i] && (r_rank[i] == last_rank);
            hit_rank  = hit_rank | (hit[i] ? r_rank[i] : '0);
            hit_value = hit_value | (hit[i] ? r_val[i] : '0);
        end
        hit_any = |hit;
        slot    = evict ? victim : free_slot;
    end

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_val   = r_val;
        n_rank  = r_rank;
        n_occ   = r_occ;
        if (hit_any) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (hit[i]) begin
                    n_rank[i] = '0;
                    if (is_put) begin
                        n_val[i] = i_req.value;
                    end
                end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
        end else if (is_put) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot[i]) begin
                    n_valid[i] = 1'b1;
                    n_key[i]   = i_req.key;
                    n_val[i]   = i_req.value;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
            if (!evict) begin
                n_occ = r_occ + OW'(1);
            end
        end
    end

    assign o_rsp.found = hit_any;
    assign o_rsp.value = hit_any ? hit_value : MISS_VALUE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_advance) begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_key  <= n_key;
            r_val  <= n_val;
            r_rank <= n_rank;
        end
    end

endmodule

FILE: rtl/lru_key_value_cache_top.sv
// A get request is registered in the request register, then its result in the result register.
// Throughput: one request per cycle, set by the combinational key compare and
// rank update over all entries; a get waits only while the result register is full
// and the result is not being taken.
// Reset (synchronous, active low): all entries invalid, occupancy zero,
// capacity 16, no request or result held.
module lru_key_value_cache_top #(
    parameter int ENTRIES = lkc_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkc_cfg_if.sink     i_cfg,
    lkc_req_if.sink     i_req,
    lkc_rsp_if.source   o_rsp
);
    import lkc_pkg::*;

    logic               r_in_valid;
    t_req               r_in;
    logic               r_out_valid;
    t_rsp               r_out;
    logic [CAP_W-1:0]   r_cap;

    logic               n_in_valid;
    logic               n_out_valid;
    logic               advance;
    logic               take_in;
    t_rsp               core_rsp;

    assign advance = r_in_valid && ((r_in.op == OP_PUT) || !r_out_valid || o_rsp.ready);
    assign take_in = i_req.valid && i_req.ready;

    assign i_req.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_out.found;
    assign o_rsp.read_value = r_out.value;

    lkc_core #(
        .ENTRIES    (ENTRIES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_req      (r_in),
        .i_capacity (r_cap),
        .o_rsp      (core_rsp)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (take_in) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance && (r_in.op == OP_GET)) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.active_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in.op    <= t_op'(i_req.operation);
            r_in.key   <= i_req.lookup_key;
            r_in.value <= i_req.write_value;
        end
        if (advance && (r_in.op == OP_GET)) begin
            r_out <= core_rsp;
        end
    end

endmodule

FILE: tb/lru_key_value_cache_top_tb.sv
`timescale 1ns / 100ps

module lru_key_value_cache_top_tb;
    import lkc_pkg::*;

    localparam int LINES      = ENTRIES_DEF;
    localparam int TAIL_WAIT  = 8;
    localparam int ITEMS_EACH = 75;

    typedef struct {
        bit               is_cfg;
        logic [CAP_W-1:0] cap;
        t_req             req;
    } t_cache_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lkc_cfg_if cfg_if ();
    lkc_req_if req_if ();
    lkc_rsp_if rsp_if ();

    lru_key_value_cache_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    t_cache_cmd              cmd_queue[$];
    t_rsp                    lookups_due[$];
    logic signed [KEY_W-1:0] key_pool[$];

    bit                      line_valid[LINES];
    logic signed [KEY_W-1:0] line_key[LINES];
    logic signed [VAL_W-1:0] line_value[LINES];
    int                      line_rank[LINES];
    int                      line_count;
    logic [CAP_W-1:0]        cap_setting;

    bit req_fire;
    bit cfg_fire;
    bit steady_flow;
    int send_gap;
    int stall_left;
    int mismatch_count;
    int get_count;
    int hit_count;
    int put_count;
    int cfg_count;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 19))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Apply one request to the cache image; return whether a lookup result follows.
    function automatic bit cache_access(input t_req r, output t_rsp rsp);
        int slot;
        int old_rank;
        int limit;
        slot = -1;
        rsp.found = 1'b0;
        rsp.value = MISS_VALUE;
        for (int i = 0; i < LINES; i++) begin
            if (line_valid[i] && line_key[i] == r.key) begin
                slot = i;
                break;
            end
        end
        if (slot >= 0) begin
            if (r.op == OP_GET) begin
                rsp.found = 1'b1;
                rsp.value = line_value[slot];
            end else begin
                line_value[slot] = r.value;
            end
            old_rank = line_rank[slot];
            for (int i = 0; i < LINES; i++)
                if (line_valid[i] && line_rank[i] < old_rank)
                    line_rank[i]++;
            line_rank[slot] = 0;
        end else if (r.op == OP_PUT) begin
            limit = (cap_setting == 0) ? 1 : (cap_setting > LINES) ? LINES : int'(cap_setting);
            if (line_count + 1 > limit && line_count > 0) begin
                for (int i = 0; i < LINES; i++)
                    if (line_valid[i] && line_rank[i] + 1 == line_count)
                        slot = i;
                if (slot >= 0) begin
                    line_valid[slot] = 1'b0;
                    line_count--;
                end
            end
            if (slot < 0) begin
                for (int i = 0; i < LINES; i++) begin
                    if (!line_valid[i]) begin
                        slot = i;
                        break;
                    end
                end
            end
            for (int i = 0; i < LINES; i++)
                if (line_valid[i])
                    line_rank[i]++;
            line_valid[slot] = 1'b1;
            line_key[slot]   = r.key;
            line_value[slot] = r.value;
            line_rank[slot]  = 0;
            line_count++;
        end
        return r.op == OP_GET;
    endfunction

    task automatic push_req(input t_op op, input logic signed [31:0] key,
                            input logic signed [31:0] value);
        t_cache_cmd c;
        c.is_cfg    = 1'b0;
        c.cap       = '0;
        c.req.op    = op;
        c.req.key   = key;
        c.req.value = value;
        cmd_queue = {cmd_queue, c};
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (cmd_queue.size() != 0 || req_if.valid || cfg_if.valid || lookups_due.size() != 0);
        repeat (TAIL_WAIT) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        t_cache_cmd c;
        wait_idle();
        c.is_cfg = 1'b1;
        c.cap    = cap;
        c.req    = '0;
        cmd_queue = {cmd_queue, c};
    endtask

    task automatic random_phase(input logic [CAP_W-1:0] cap, input int count);
        int limit;
        int pool_size;
        write_capacity(cap);
        limit = (cap == 0) ? 1 : (cap > LINES) ? LINES : int'(cap);
        pool_size = limit + $urandom_range(1, limit + 2);
        key_pool.delete();
        repeat (pool_size) key_pool = {key_pool, rand_word()};
        repeat (count) begin
            push_req($urandom_range(0, 1) ? OP_PUT : OP_GET,
                     ($urandom_range(0, 99) < 85) ?
                         key_pool[$urandom_range(0, pool_size - 1)] : rand_word(),
                     rand_word());
        end
    endtask

    // driver: requests and capacity writes in queue order
    always @(negedge i_clk) begin
        t_cache_cmd c;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            cfg_if.valid <= 1'b0;
        end else if ((req_if.valid && !req_fire) || (cfg_if.valid && !cfg_fire)) begin
            // hold until the transaction completes
        end else if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
            cfg_if.valid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
            c = cmd_queue[0];
            cmd_queue.delete(0);
            if (c.is_cfg) begin
                cfg_if.valid           <= 1'b1;
                cfg_if.active_capacity <= c.cap;
                req_if.valid           <= 1'b0;
            end else begin
                req_if.valid       <= 1'b1;
                req_if.operation   <= c.req.op;
                req_if.lookup_key  <= c.req.key;
                req_if.write_value <= c.req.value;
                cfg_if.valid       <= 1'b0;
            end
            send_gap = pick_gap();
        end else begin
            req_if.valid <= 1'b0;
            cfg_if.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // monitor: check results, then update the cache image
    always @(posedge i_clk) begin
        t_req acc;
        t_rsp want;
        t_rsp got;
        req_fire = 1'b0;
        cfg_fire = 1'b0;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.found = rsp_if.found;
                got.value = rsp_if.read_value;
                if (lookups_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result found=%0b value=%0d",
                                 $realtime, got.found, got.value);
                end else begin
                    want = lookups_due[0];
                    lookups_due.delete(0);
                    if (got.found !== want.found || got.value !== want.value) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: exp found=%0b value=%0d, got found=%0b value=%0d",
                                     $realtime, want.found, want.value, got.found, got.value);
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                cfg_fire    = 1'b1;
                cap_setting = cfg_if.active_capacity;
                cfg_count++;
            end
            if (req_if.valid && req_if.ready) begin
                req_fire  = 1'b1;
                acc.op    = t_op'(req_if.operation);
                acc.key   = req_if.lookup_key;
                acc.value = req_if.write_value;
                if (cache_access(acc, want)) begin
                    lookups_due = {lookups_due, want};
                    get_count++;
                    if (want.found)
                        hit_count++;
                end else begin
                    put_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [CAP_W-1:0] caps[8];
        i_rst_n                = 1'b0;
        req_if.valid           = 1'b0;
        req_if.operation       = OP_GET;
        req_if.lookup_key      = '0;
        req_if.write_value     = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.active_capacity = '0;
        rsp_if.ready           = 1'b0;
        for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
            line_rank[i]  = 0;
        end
        line_count     = 0;
        cap_setting    = CAP_RESET;
        send_gap       = 0;
        stall_left     = 0;
        steady_flow    = 1'b0;
        mismatch_count = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_capacity(2);
        push_req(OP_GET, 32'sh0, 32'sh12345678);
        push_req(OP_PUT, 32'sh7fffffff, 32'sh80000000);
        push_req(OP_PUT, 32'sh80000000, 32'sh7fffffff);
        push_req(OP_GET, 32'sh7fffffff, '0);
        push_req(OP_GET, 32'sh80000000, '1);
        push_req(OP_PUT, -32'sd1, 32'sh0);
        push_req(OP_GET, 32'sh7fffffff, '0);
        push_req(OP_GET, -32'sd1, '0);
        push_req(OP_PUT, 32'sh80000000, -32'sd1);
        push_req(OP_GET, 32'sh80000000, '0);
        push_req(OP_PUT, 32'sh0, 32'sh5a5a5a5a);
        push_req(OP_GET, -32'sd1, 32'sha5a5a5a5);
        push_req(OP_GET, 32'sh0, '1);

        write_capacity(0);
        push_req(OP_PUT, 32'sd1, 32'sd11);
        push_req(OP_PUT, 32'sd2, 32'sd22);
        push_req(OP_GET, 32'sd1, '0);
        push_req(OP_GET, 32'sd2, '0);

        caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd17, 5'd5, CAP_W'($urandom_range(0, 31)), 5'd12};
        foreach (caps[p]) begin
            steady_flow = (p % 3 == 1);
            random_phase(caps[p], ITEMS_EACH);
        end
        wait_idle();
        steady_flow = 1'b0;

        if (lookups_due.size() != 0)
            mismatch_count += lookups_due.size();
        $display("Covered %0d gets (%0d hits) and %0d puts over %0d capacity writes",
                 get_count, hit_count, put_count, cfg_count);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
